### rtl/sc1a_pkg.sv
package sc1a_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CharW = 7;
    localparam int unsigned CodeW = 6;

    localparam logic [ByteW-1:0] PREFIX_BYTE   = 8'hE0;
    localparam logic [6:0]       LAST_CODE     = 7'h3A;
    localparam logic [6:0]       CODE_SHIFT_L  = 7'h2A;
    localparam logic [6:0]       CODE_SHIFT_R  = 7'h36;
    localparam logic [6:0]       CODE_ALT      = 7'h38;
    localparam logic [6:0]       CODE_CTRL     = 7'h1D;
    localparam logic [6:0]       CODE_CAPS     = 7'h3A;
    localparam logic [6:0]       CODE_BACKTICK = 7'h29;

    localparam logic [CharW-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CharW-1:0] CHAR_LOWER_D = 7'h64;
    localparam logic [CharW-1:0] CHAR_LOWER_L = 7'h6C;
    localparam logic [CharW-1:0] CHAR_LOWER_U = 7'h75;

    typedef struct packed {
        logic prefix_pending;
        logic shift_held;
        logic ctrl_held;
        logic alt_held;
        logic caps_lock_on;
    } flags_t;

    typedef struct packed {
        logic             emit;
        logic [CharW-1:0] char_code;
    } result_t;

    function automatic logic is_symbol_key(logic [CodeW-1:0] code);
        logic [6:0] c;
        begin
            c = {1'b0, code};
            is_symbol_key = (c >= 7'h02 && c <= 7'h0D) || (c >= 7'h33 && c <= 7'h35) ||
                            c == CODE_BACKTICK || c == 7'h1A || c == 7'h1B ||
                            c == 7'h2B || c == 7'h27 || c == 7'h28;
        end
    endfunction

    // Two-column map: column 0 plain, column 1 shifted.
    function automatic logic [CharW-1:0] char_lookup(logic [CodeW-1:0] code, logic col);
        logic [CharW-1:0] lo;
        logic [CharW-1:0] hi;
        begin
            lo = '0;
            hi = '0;
            case (code)
                6'h01: begin lo = 7'h1B; hi = 7'h1B; end
                6'h02: begin lo = 7'h31; hi = 7'h21; end
                6'h03: begin lo = 7'h32; hi = 7'h40; end
                6'h04: begin lo = 7'h33; hi = 7'h23; end
                6'h05: begin lo = 7'h34; hi = 7'h24; end
                6'h06: begin lo = 7'h35; hi = 7'h25; end
                6'h07: begin lo = 7'h36; hi = 7'h5E; end
                6'h08: begin lo = 7'h37; hi = 7'h26; end
                6'h09: begin lo = 7'h38; hi = 7'h2A; end
                6'h0A: begin lo = 7'h39; hi = 7'h28; end
                6'h0B: begin lo = 7'h30; hi = 7'h29; end
                6'h0C: begin lo = 7'h2D; hi = 7'h5F; end
                6'h0D: begin lo = 7'h3D; hi = 7'h2B; end
                6'h0E: begin lo = 7'h08; hi = 7'h08; end
                6'h0F: begin lo = 7'h09; hi = 7'h09; end
                6'h10: begin lo = 7'h71; hi = 7'h51; end
                6'h11: begin lo = 7'h77; hi = 7'h57; end
                6'h12: begin lo = 7'h65; hi = 7'h45; end
                6'h13: begin lo = 7'h72; hi = 7'h52; end
                6'h14: begin lo = 7'h74; hi = 7'h54; end
                6'h15: begin lo = 7'h79; hi = 7'h59; end
                6'h16: begin lo = 7'h75; hi = 7'h55; end
                6'h17: begin lo = 7'h69; hi = 7'h49; end
                6'h18: begin lo = 7'h6F; hi = 7'h4F; end
                6'h19: begin lo = 7'h70; hi = 7'h50; end
                6'h1A: begin lo = 7'h5B; hi = 7'h7B; end
                6'h1B: begin lo = 7'h5D; hi = 7'h7D; end
                6'h1C: begin lo = 7'h0D; hi = 7'h0D; end
                6'h1E: begin lo = 7'h61; hi = 7'h41; end
                6'h1F: begin lo = 7'h73; hi = 7'h53; end
                6'h20: begin lo = 7'h64; hi = 7'h44; end
                6'h21: begin lo = 7'h66; hi = 7'h46; end
                6'h22: begin lo = 7'h67; hi = 7'h47; end
                6'h23: begin lo = 7'h68; hi = 7'h48; end
                6'h24: begin lo = 7'h6A; hi = 7'h4A; end
                6'h25: begin lo = 7'h6B; hi = 7'h4B; end
                6'h26: begin lo = 7'h6C; hi = 7'h4C; end
                6'h27: begin lo = 7'h3B; hi = 7'h3A; end
                6'h28: begin lo = 7'h27; hi = 7'h22; end
                6'h29: begin lo = 7'h60; hi = 7'h7E; end
                6'h2B: begin lo = 7'h5C; hi = 7'h7C; end
                6'h2C: begin lo = 7'h7A; hi = 7'h5A; end
                6'h2D: begin lo = 7'h78; hi = 7'h58; end
                6'h2E: begin lo = 7'h63; hi = 7'h43; end
                6'h2F: begin lo = 7'h76; hi = 7'h56; end
                6'h30: begin lo = 7'h62; hi = 7'h42; end
                6'h31: begin lo = 7'h6E; hi = 7'h4E; end
                6'h32: begin lo = 7'h6D; hi = 7'h4D; end
                6'h33: begin lo = 7'h2C; hi = 7'h3C; end
                6'h34: begin lo = 7'h2E; hi = 7'h3E; end
                6'h35: begin lo = 7'h2F; hi = 7'h3F; end
                6'h37: begin lo = 7'h2A; hi = 7'h2A; end
                6'h39: begin lo = 7'h20; hi = 7'h20; end
                default: begin lo = '0; hi = '0; end
            endcase
            char_lookup = col ? hi : lo;
        end
    endfunction

endpackage

### rtl/sc1a_decode.sv
module sc1a_decode (
    input  logic [sc1a_pkg::ByteW-1:0] scan_byte,
    input  sc1a_pkg::flags_t           flags,
    output sc1a_pkg::flags_t           flags_next,
    output sc1a_pkg::result_t          result
);
    import sc1a_pkg::*;

    logic [6:0]       code;
    logic             is_break;
    logic             col;
    logic [CharW-1:0] ch;

    assign code     = scan_byte[6:0];
    assign is_break = scan_byte[7];

    always_comb
    begin
        col = is_symbol_key(code[CodeW-1:0]) ? flags.shift_held
                                              : (flags.shift_held ^ flags.caps_lock_on);
        ch  = char_lookup(code[CodeW-1:0], col);
        // Ctrl shortcuts: map lowercase l, u, d onto control codes
        if (flags.ctrl_held &&
            (ch == CHAR_LOWER_L || ch == CHAR_LOWER_U || ch == CHAR_LOWER_D))
        begin
            ch = ch - CHAR_LOWER_A;
        end
    end

    always_comb
    begin
        flags_next       = flags;
        result.emit      = 1'b0;
        result.char_code = ch;
        if (scan_byte == PREFIX_BYTE)
        begin
            flags_next.prefix_pending = 1'b1;
        end
        else if (flags.prefix_pending)
        begin
            // drop the second byte of an extended key
            flags_next.prefix_pending = 1'b0;
        end
        else if (code > LAST_CODE)
        begin
            flags_next = flags;
        end
        else if (is_break)
        begin
            if (code == CODE_ALT)
                flags_next.alt_held = 1'b0;
            else if (code == CODE_SHIFT_L || code == CODE_SHIFT_R)
                flags_next.shift_held = 1'b0;
            else if (code == CODE_CTRL)
                flags_next.ctrl_held = 1'b0;
        end
        else if (code == CODE_ALT)
        begin
            flags_next.alt_held = 1'b1;
        end
        else if (code == CODE_SHIFT_L || code == CODE_SHIFT_R)
        begin
            flags_next.shift_held = 1'b1;
        end
        else if (code == CODE_CTRL)
        begin
            flags_next.ctrl_held = 1'b1;
        end
        else if (code == CODE_CAPS)
        begin
            flags_next.caps_lock_on = ~flags.caps_lock_on;
        end
        else
        begin
            result.emit = 1'b1;
        end
    end

endmodule

### rtl/scan_code_set1_to_ascii.sv
// Channel   Signals                       Direction  Meaning
// input     in_valid, in_stall, scan_byte  in/out     one raw set-1 scan byte per request
// output    out_valid, out_stall, char_code out/in    one ASCII or control code per request
//
// One byte per cycle while the input is not stalled; a byte that gives a character passes
// through the input register, which feeds the decode, and then through the result register.
// Reset clears the prefix, modifier and caps lock flags and empties both registers.
// A stall on the output holds the result; the input register still drains bytes
// that give no character, then stalls the input only when it holds a character.
module scan_code_set1_to_ascii (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [sc1a_pkg::ByteW-1:0] scan_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [sc1a_pkg::CharW-1:0] char_code
);
    import sc1a_pkg::*;

    logic             in_valid_reg;
    logic [ByteW-1:0] byte_reg;
    flags_t           flags_reg;
    flags_t           flags_next;
    result_t          result;
    logic             out_valid_reg;
    logic [CharW-1:0] char_reg;
    logic             out_free;
    logic             advance;
    logic             in_take;

    sc1a_decode u_decode (
        .scan_byte  (byte_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .result     (result)
    );

    assign out_free = ~out_valid_reg | ~out_stall;
    // a byte with no character never waits on the output side
    assign advance  = in_valid_reg & (out_free | ~result.emit);
    assign in_stall = in_valid_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (in_take || advance)
                in_valid_reg <= in_take;
            if (advance)
                flags_reg <= flags_next;
            if (advance && result.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= scan_byte;
        if (advance && result.emit)
            char_reg <= result.char_code;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;

endmodule

### test/tb_scan_code_set1_to_ascii.sv
`timescale 1ns / 1ps

module tb_scan_code_set1_to_ascii;

    import sc1a_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned QUIET_TAIL = 150;
    localparam int unsigned END_WAIT = 16;

    localparam logic [ByteW-1:0] BREAK_BIT = 8'h80;
    localparam logic [ByteW-1:0] KEY_ZERO = 8'h00;
    localparam logic [ByteW-1:0] KEY_1 = 8'h02;
    localparam logic [ByteW-1:0] KEY_U = 8'h16;
    localparam logic [ByteW-1:0] KEY_A = 8'h1E;
    localparam logic [ByteW-1:0] KEY_D = 8'h20;
    localparam logic [ByteW-1:0] KEY_L = 8'h26;
    localparam logic [ByteW-1:0] KEY_F1 = 8'h3B;

    localparam logic [8*10-1:0] DIGIT_ROW = "1234567890";
    localparam logic [8*10-1:0] DIGIT_ROW_SHIFTED = "!@#$%^&*()";
    localparam logic [8*10-1:0] TOP_ROW = "qwertyuiop";
    localparam logic [8*9-1:0] HOME_ROW = "asdfghjkl";
    localparam logic [8*7-1:0] BOTTOM_ROW = "zxcvbnm";

    typedef struct packed {
        logic             drain;
        logic [ByteW-1:0] value;
    } scan_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ByteW-1:0] scan_byte = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CharW-1:0] char_code;

    scan_req_t pending_scans[$];
    logic [CharW-1:0] expected_chars[$];
    flags_t kb_flags = '0;
    logic calm = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;

    scan_code_set1_to_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .scan_byte (scan_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code)
    );

    always #1 clk = ~clk;

    function automatic logic symbol_key(logic [6:0] c);
        return c inside {[7'h02:7'h0D], [7'h33:7'h35], CODE_BACKTICK,
                         7'h1A, 7'h1B, 7'h2B, 7'h27, 7'h28};
    endfunction

    // Pair holds {plain, shifted}; letters shift by flipping bit 5.
    function automatic logic [CharW-1:0] map_char(logic [5:0] code, logic col);
        logic [15:0] pair;
        int i;
        i = int'(code);
        if (code >= 6'h02 && code <= 6'h0B)
            pair = {DIGIT_ROW[8*(11-i) +: 8], DIGIT_ROW_SHIFTED[8*(11-i) +: 8]};
        else if (code >= 6'h10 && code <= 6'h19)
            pair = {TOP_ROW[8*(25-i) +: 8], TOP_ROW[8*(25-i) +: 8] ^ 8'h20};
        else if (code >= 6'h1E && code <= 6'h26)
            pair = {HOME_ROW[8*(38-i) +: 8], HOME_ROW[8*(38-i) +: 8] ^ 8'h20};
        else if (code >= 6'h2C && code <= 6'h32)
            pair = {BOTTOM_ROW[8*(50-i) +: 8], BOTTOM_ROW[8*(50-i) +: 8] ^ 8'h20};
        else
        begin
            case (code)
                6'h01: pair = 16'h1B1B;
                6'h0C: pair = "-_";
                6'h0D: pair = "=+";
                6'h0E: pair = 16'h0808;
                6'h0F: pair = 16'h0909;
                6'h1A: pair = "[{";
                6'h1B: pair = "]}";
                6'h1C: pair = 16'h0D0D;
                6'h27: pair = ";:";
                6'h28: pair = "'\"";
                6'h29: pair = "`~";
                6'h2B: pair = "\\|";
                6'h33: pair = ",<";
                6'h34: pair = ".>";
                6'h35: pair = "/?";
                6'h37: pair = "**";
                6'h39: pair = "  ";
                default: pair = 16'h0000;
            endcase
        end
        return col ? pair[6:0] : pair[14:8];
    endfunction

    // Advance the keyboard flags by one byte and queue the character it yields.
    function automatic void decode_byte(logic [ByteW-1:0] b);
        logic [6:0] code;
        logic col;
        logic [CharW-1:0] ch;
        code = b[6:0];
        if (b == PREFIX_BYTE)
            kb_flags.prefix_pending = 1'b1;
        else if (kb_flags.prefix_pending)
            kb_flags.prefix_pending = 1'b0;
        else if (code <= LAST_CODE)
        begin
            if (b[7])
            begin
                if (code == CODE_ALT)
                    kb_flags.alt_held = 1'b0;
                else if (code == CODE_SHIFT_L || code == CODE_SHIFT_R)
                    kb_flags.shift_held = 1'b0;
                else if (code == CODE_CTRL)
                    kb_flags.ctrl_held = 1'b0;
            end
            else if (code == CODE_ALT)
                kb_flags.alt_held = 1'b1;
            else if (code == CODE_SHIFT_L || code == CODE_SHIFT_R)
                kb_flags.shift_held = 1'b1;
            else if (code == CODE_CTRL)
                kb_flags.ctrl_held = 1'b1;
            else if (code == CODE_CAPS)
                kb_flags.caps_lock_on = ~kb_flags.caps_lock_on;
            else
            begin
                col = symbol_key(code) ? kb_flags.shift_held
                                       : kb_flags.shift_held ^ kb_flags.caps_lock_on;
                ch = map_char(code[5:0], col);
                if (kb_flags.ctrl_held &&
                    (ch == CHAR_LOWER_L || ch == CHAR_LOWER_U || ch == CHAR_LOWER_D))
                    ch = ch - CHAR_LOWER_A;
                expected_chars.push_back(ch);
            end
        end
    endfunction

    task automatic add_scan(logic [ByteW-1:0] value, logic drain);
        pending_scans.push_back('{drain: drain, value: value});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        logic [ByteW-1:0] next_byte;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            scan_byte <= '0;
            kb_flags = '0;
            send_gap = 0;
        end
        else
        begin
            calm = pending_scans.size() < QUIET_TAIL;
            next_valid = in_valid;
            next_byte = scan_byte;
            if (in_valid && !in_stall)
            begin
                decode_byte(scan_byte);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (pending_scans.size() != 0 &&
                         !(pending_scans[0].drain && expected_chars.size() != 0))
                begin
                    next_byte = pending_scans[0].value;
                    pending_scans.pop_front();
                    next_valid = 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 13);
                end
            end
            in_valid <= next_valid;
            scan_byte <= next_byte;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [CharW-1:0] want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected char_code: expected none, actual %h",
                             $time, char_code);
                    errors++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_code !== want)
                    begin
                        $display("%0t: char_code mismatch: expected %h, actual %h",
                                 $time, want, char_code);
                        errors++;
                    end
                end
            end
            // A stall burst holds out_stall high until recv_gap has counted down to zero.
            if (recv_gap != 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(0, 12);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** scan_code_set1_to_ascii: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned pick;
        logic [ByteW-1:0] b;

        add_scan(KEY_ZERO, 1'b0);
        add_scan(KEY_A, 1'b0);
        add_scan({1'b0, CODE_CAPS}, 1'b0);
        add_scan(KEY_A, 1'b0);
        add_scan(KEY_1, 1'b0);
        add_scan({1'b0, CODE_SHIFT_R}, 1'b0);
        add_scan(KEY_A, 1'b0);
        add_scan(KEY_1, 1'b0);
        add_scan(BREAK_BIT | {1'b0, CODE_SHIFT_R}, 1'b0);
        add_scan({1'b0, CODE_CAPS}, 1'b0);
        add_scan({1'b0, CODE_CTRL}, 1'b0);
        add_scan(KEY_L, 1'b0);
        add_scan(KEY_U, 1'b0);
        add_scan(KEY_D, 1'b0);
        add_scan(BREAK_BIT | {1'b0, CODE_CTRL}, 1'b0);
        add_scan({1'b0, CODE_ALT}, 1'b0);
        add_scan(KEY_A, 1'b0);
        add_scan(BREAK_BIT | {1'b0, CODE_ALT}, 1'b0);
        // Prefix twice in a row, then the extended half that must be dropped.
        add_scan(PREFIX_BYTE, 1'b0);
        add_scan(PREFIX_BYTE, 1'b0);
        add_scan(KEY_A, 1'b0);
        add_scan(KEY_F1, 1'b0);
        add_scan(8'hFF, 1'b0);
        add_scan(BREAK_BIT | KEY_A, 1'b0);

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                b = 8'($urandom_range(0, int'(LAST_CODE)));
            else if (pick < 65)
            begin
                case ($urandom_range(0, 3))
                    0: b = {1'b0, CODE_SHIFT_L};
                    1: b = {1'b0, CODE_SHIFT_R};
                    2: b = {1'b0, CODE_CTRL};
                    default: b = {1'b0, CODE_ALT};
                endcase
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 4))
                    0: b = BREAK_BIT | {1'b0, CODE_SHIFT_L};
                    1: b = BREAK_BIT | {1'b0, CODE_SHIFT_R};
                    2: b = BREAK_BIT | {1'b0, CODE_CTRL};
                    3: b = BREAK_BIT | {1'b0, CODE_ALT};
                    default: b = BREAK_BIT | 8'($urandom_range(0, int'(LAST_CODE)));
                endcase
            end
            else if (pick < 88)
            begin
                add_scan(PREFIX_BYTE, n == RANDOM_ITEMS / 2);
                n++;
                b = 8'($urandom_range(0, 255));
            end
            else
                b = 8'($urandom_range(0, 255));
            add_scan(b, n == 0 || n == RANDOM_ITEMS / 2);
            n++;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_scans.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        if (errors == 0)
            $display("** scan_code_set1_to_ascii: PASSED **");
        else
            $display("** scan_code_set1_to_ascii: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/sc1a_pkg.sv
rtl/sc1a_decode.sv
rtl/scan_code_set1_to_ascii.sv
test/tb_scan_code_set1_to_ascii.sv
